// ----- rtl/core/upd_pkg.sv -----
// Package with shared types, character codes and digit helpers for the URL percent decoder.
package upd_pkg;

  // Character codes used by the decoder.
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7A;
  localparam logic [7:0] HexTen    = 8'd10;
  localparam int unsigned NibbleW  = 4;

  // Depth of the command queue between front and back; keep it at least 2.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QIdxW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Escape tracking of the front end.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upd_phase_e;

  // One queued command: one or two output bytes. With two set, b0 goes out with
  // last cleared and b1 follows with the item's last flag.
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } upd_cmd_t;

  // Unvalidated hex digit value, wrapping to 8 bits.
  function automatic logic [7:0] digit_value(input logic [7:0] b);
    logic [7:0] u;
    u = b;
    if (b <= ChNine) begin
      return b - ChZero;
    end
    if (u >= ChLowerA && u <= ChLowerZ) begin
      u = u - (ChLowerA - ChUpperA);
    end
    return u - ChUpperA + HexTen;
  endfunction

  // Plain data byte: a plus sign stands for a space.
  function automatic logic [7:0] plain_byte(input logic [7:0] b);
    return (b == ChPlus) ? ChSpace : b;
  endfunction

endpackage

// ----- rtl/core/upd_if.sv -----
// Stream interfaces for the encoded input bytes and the decoded output bytes.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- rtl/core/url_percent_decoder.sv -----
// Top level of the streaming URL percent decoder: front end, command queue and output stage.
// The front end writes each command into the queue when it accepts the item completing it,
// and the output stage then moves it into the output register, behind any queued commands.
// Throughput: one item per cycle while the queue has room. An item that yields two results
// holds the output stage for both; once the two-entry queue fills behind it, input waits.
// Reset (asynchronous, active low) clears the escape state, empties the queue and drops
// the output valid; payload registers are not reset.
module url_percent_decoder
  import upd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_i,
  upd_out_if.source out_o
);

  // The front end classifies each accepted byte. A percent sign and the first hex
  // digit only update the escape state; every other byte, the second digit, and the
  // end-of-string cases produce a command for the queue. The front end takes a byte
  // whenever the queue has room, so it never waits on the output handshake directly.
  logic     push;
  upd_cmd_t push_cmd;
  logic     q_ready;
  logic     q_valid;
  upd_cmd_t q_cmd;
  logic     pop;

  upd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // The queue lets the output stage stall on its own, for example while it sends the
  // second byte of a two-item command. Input only waits once both entries are taken.
  upd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (pop)
  );

  // The output stage owns the output register and sends one item per cycle while the receiver is ready.
  upd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .out_o     (out_o)
  );

  // The front end must never push a command into a full queue.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> q_ready)
    else $error("command pushed into a full queue");

  // The output stage must only pop when the queue holds a command.
  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("command popped from an empty queue");

  // The only two-result case is an unfinished escape, so its first byte is a percent sign.
  a_two_starts_with_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_cmd.two) |-> (push_cmd.b0 == ChPercent && push_cmd.last))
    else $error("two-item command without a leading percent sign");

endmodule

// ----- rtl/core/upd_front.sv -----
// Front end: accepts encoded bytes, tracks the escape state and builds queue commands.
module upd_front
  import upd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  upd_in_if.sink        in_i,
  input  logic          q_ready_i,
  output logic          push_o,
  output upd_cmd_t      cmd_o
);

  upd_phase_e phase_q, phase_d;
  logic [NibbleW-1:0] nib_q, nib_d;
  logic accept;
  logic [7:0] dval;

  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid & q_ready_i;
  assign dval       = digit_value(in_i.in_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      nib_q   <= '0;
    end else begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    nib_d   = nib_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    if (accept) begin
      unique case (phase_q)
        PH_PCT: begin
          if (in_i.in_last) begin
            // String ended one byte into an escape: '%', then the byte as plain text.
            push_o     = 1'b1;
            cmd_o.two  = 1'b1;
            cmd_o.b0   = ChPercent;
            cmd_o.b1   = plain_byte(in_i.in_byte);
            cmd_o.last = 1'b1;
            phase_d    = PH_IDLE;
          end else begin
            nib_d   = dval[NibbleW-1:0];
            phase_d = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          push_o     = 1'b1;
          cmd_o.b0   = {nib_q, {NibbleW{1'b0}}} + dval;
          cmd_o.last = in_i.in_last;
          phase_d    = PH_IDLE;
        end
        default: begin
          if (in_i.in_byte == ChPercent && !in_i.in_last) begin
            phase_d = PH_PCT;
          end else begin
            push_o     = 1'b1;
            cmd_o.b0   = plain_byte(in_i.in_byte);
            cmd_o.last = in_i.in_last;
            phase_d    = PH_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/upd_fifo.sv -----
// Short command queue that decouples the front end from the output stage.
module upd_fifo
  import upd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  upd_cmd_t cmd_i,
  output logic     ready_o,
  output logic     valid_o,
  output upd_cmd_t cmd_o,
  input  logic     pop_i
);

  upd_cmd_t mem_q [QDepth];
  logic [QIdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign ready_o = (cnt_q != QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  function automatic logic [QIdxW-1:0] next_ptr(input logic [QIdxW-1:0] p);
    return (p == QIdxW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/core/upd_back.sv -----
// Back end: expands queue commands into output items through an output register.
module upd_back
  import upd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  upd_cmd_t q_cmd_i,
  output logic     pop_o,
  upd_out_if.source out_o
);

  logic       ov_q, ov_d;
  logic [7:0] ob_q, ob_d;
  logic       ol_q, ol_d;
  logic       pend_q, pend_d;
  logic [7:0] pb_q, pb_d;
  logic       pl_q, pl_d;
  logic       load;

  assign out_o.valid    = ov_q;
  assign out_o.out_byte = ob_q;
  assign out_o.out_last = ol_q;

  // The output register may take a new item when empty or being drained.
  assign load = !ov_q || out_o.ready;

  always_comb begin
    ov_d   = ov_q;
    ob_d   = ob_q;
    ol_d   = ol_q;
    pend_d = pend_q;
    pb_d   = pb_q;
    pl_d   = pl_q;
    pop_o  = 1'b0;
    if (load) begin
      if (pend_q) begin
        ov_d   = 1'b1;
        ob_d   = pb_q;
        ol_d   = pl_q;
        pend_d = 1'b0;
      end else if (q_valid_i) begin
        pop_o  = 1'b1;
        ov_d   = 1'b1;
        ob_d   = q_cmd_i.b0;
        ol_d   = q_cmd_i.last & ~q_cmd_i.two;
        pend_d = q_cmd_i.two;
        pb_d   = q_cmd_i.b1;
        pl_d   = q_cmd_i.last;
      end else begin
        ov_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      ov_q   <= ov_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    ol_q <= ol_d;
    pb_q <= pb_d;
    pl_q <= pl_d;
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the streaming URL percent decoder.
`timescale 1ns / 100ps

module testbench;
  import upd_pkg::*;

  // The longest correct run stays far below this. It allows for two results per
  // item, receiver stalls and the sender's gaps.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 1900;

  // How the receiver paces its ready line during one stretch.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_PATTERN,
    RX_BURSTY
  } rx_mode_e;

  // One encoded byte waiting to be sent. With wait_drain set, the sender holds it
  // back until every decoded byte that is still owed has arrived.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       wait_drain;
  } enc_item_t;

  // One decoded byte that the decoder owes us.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_item_t;

  logic clk;
  logic rst_n = 1'b0;

  // Values driven onto the channels. They start at known values at time zero.
  logic       drv_valid = 1'b0;
  logic [7:0] drv_byte  = 8'h00;
  logic       drv_last  = 1'b0;
  logic       drv_ready = 1'b0;

  upd_in_if  enc_bus ();
  upd_out_if dec_bus ();

  assign enc_bus.valid   = drv_valid;
  assign enc_bus.in_byte = drv_byte;
  assign enc_bus.in_last = drv_last;
  assign dec_bus.ready   = drv_ready;

  url_percent_decoder i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (enc_bus),
    .out_o  (dec_bus)
  );

  // Encoded bytes still to be sent, and decoded bytes still owed by the decoder.
  enc_item_t enc_pending_q[$];
  dec_item_t dec_owed_q[$];

  // Our own copy of the escape tracking: where we are in a percent sequence and
  // the value of the first digit once it has been seen.
  upd_phase_e esc_phase = PH_IDLE;
  logic [3:0] esc_high  = 4'h0;

  int unsigned issue_cnt   = 0;
  int unsigned accept_cnt  = 0;
  int unsigned decoded_cnt = 0;
  int unsigned string_cnt  = 0;
  int unsigned escape_cnt  = 0;
  int unsigned split_cnt   = 0;
  int unsigned fail_cnt    = 0;
  int unsigned cycle_cnt   = 0;

  // Sender pacing: items left in the current burst, idle cycles before the next.
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;

  // Receiver pacing.
  rx_mode_e    rx_mode    = RX_FREE;
  int unsigned rx_left    = 0;
  int unsigned rx_hold    = 0;
  logic [7:0]  rx_pattern = 8'h01;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Value of one hex digit. Nothing is validated: anything above '9' is taken as
  // a letter, lower case is folded to upper case by clearing bit 5, and the
  // arithmetic simply wraps at 8 bits.
  function automatic logic [7:0] hex_digit_value(input logic [7:0] c);
    logic [7:0] up;
    if (c <= ChNine) begin
      return c - ChZero;
    end
    up = (c >= ChLowerA && c <= ChLowerZ) ? (c & 8'hDF) : c;
    return up - ChUpperA + HexTen;
  endfunction

  // A byte outside an escape: only the plus sign changes, into a space.
  function automatic logic [7:0] unplus(input logic [7:0] c);
    return (c == ChPlus) ? ChSpace : c;
  endfunction

  function automatic dec_item_t dec_item(input logic [7:0] data, input logic last);
    dec_item_t d;
    d.data = data;
    d.last = last;
    return d;
  endfunction

  // Advances our escape tracking by one accepted byte and queues the decoded
  // bytes that it yields, zero, one or two of them.
  task automatic predict_decode(input logic [7:0] c, input logic last);
    logic [7:0] digit;
    digit = hex_digit_value(c);
    case (esc_phase)
      PH_PCT: begin
        if (last) begin
          // The string ends one byte into an escape: the percent sign goes out
          // literally and the stray byte is treated as plain text.
          dec_owed_q.push_back(dec_item(ChPercent, 1'b0));
          dec_owed_q.push_back(dec_item(unplus(c), 1'b1));
          split_cnt++;
          esc_phase = PH_IDLE;
        end else begin
          esc_high  = digit[3:0];
          esc_phase = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        dec_owed_q.push_back(dec_item({esc_high, 4'h0} + digit, last));
        escape_cnt++;
        esc_phase = PH_IDLE;
      end
      default: begin
        // Idle. A percent sign opens an escape unless it is the final byte,
        // in which case it stands for itself.
        esc_phase = PH_IDLE;
        if (c == ChPercent && !last) begin
          esc_phase = PH_PCT;
        end else if (c == ChPercent) begin
          dec_owed_q.push_back(dec_item(ChPercent, 1'b1));
        end else begin
          dec_owed_q.push_back(dec_item(unplus(c), last));
        end
      end
    endcase
    if (last) begin
      string_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_byte(input logic [7:0] c, input logic last, input logic wait_drain);
    enc_item_t e;
    e.code       = c;
    e.last       = last;
    e.wait_drain = wait_drain;
    enc_pending_q.push_back(e);
  endtask

  // Queues a whole string; its final character carries the last flag.
  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i], i == s.len() - 1, 1'b0);
    end
  endtask

  // Mostly real hex digits of either case, sometimes any byte at all so that
  // the unchecked digit arithmetic and its wrap are exercised.
  function automatic logic [7:0] pick_digit();
    string hex_chars;
    hex_chars = "0123456789abcdefABCDEF";
    if ($urandom_range(0, 4) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
  endfunction

  // Builds one random string. Most of it is well-formed text: printable characters, plus
  // signs and complete escapes. Stray percent signs, raw bytes and escapes cut
  // short by the end of the string make up the rest.
  task automatic queue_random_string(input logic wait_drain);
    logic [7:0] chars[$];
    int unsigned len;
    int unsigned kind;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
    while (chars.size() < len) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        chars.push_back(ChPercent);
        chars.push_back(pick_digit());
        chars.push_back(pick_digit());
      end else if (kind < 40) begin
        chars.push_back(ChPlus);
      end else if (kind < 46) begin
        chars.push_back(ChPercent);
      end else if (kind < 58) begin
        chars.push_back(8'($urandom_range(0, 255)));
      end else begin
        chars.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
    end
    // Now and then the string ends inside an escape.
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      chars.push_back(ChPercent);
    end else if (kind == 1) begin
      chars.push_back(ChPercent);
      chars.push_back(($urandom_range(0, 3) == 0) ? ChPlus : pick_digit());
    end
    for (int i = 0; i < chars.size(); i++) begin
      queue_byte(chars[i], i == chars.size() - 1, wait_drain && i == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: presents items at the falling edge in bursts with random gaps, and
  // keeps an item on the bus until the decoder has taken it.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : enc_driver
    enc_item_t nxt;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (drv_valid && accept_cnt != issue_cnt) begin
      // Still waiting for the handshake; everything stays as it is.
    end else if (gap_left > 0) begin
      gap_left--;
      drv_valid <= 1'b0;
    end else if (enc_pending_q.size() != 0 &&
                 !(enc_pending_q[0].wait_drain && dec_owed_q.size() != 0)) begin
      nxt = enc_pending_q.pop_front();
      drv_valid <= 1'b1;
      drv_byte  <= nxt.code;
      drv_last  <= nxt.last;
      issue_cnt++;
      if (burst_left <= 1) begin
        // Occasionally a long burst, so that stretches without any gap occur.
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      drv_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: changes its ready line at the falling edge, in stretches of free
  // flow, coin flips, a rotating pattern and rare long stalls.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : dec_pacing
    logic rdy;
    if (rx_left == 0) begin
      rx_mode    = rx_mode_e'($urandom_range(0, 3));
      rx_left    = $urandom_range(30, 200);
      rx_pattern = 8'($urandom) | 8'h01;
      rx_hold    = 0;
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE: begin
        rdy = 1'b1;
      end
      RX_COIN: begin
        rdy = 1'($urandom_range(0, 1));
      end
      RX_PATTERN: begin
        rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
        rdy        = rx_pattern[0];
      end
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          rdy = 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
          rx_hold = $urandom_range(3, 15);
          rdy     = 1'b0;
        end else begin
          rdy = 1'b1;
        end
      end
    endcase
    drv_ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, checks any decoded byte that is taken against
  // the oldest one owed, then feeds any accepted encoded byte to the predictor.
  // The check comes first; a byte accepted at this edge cannot appear yet.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : stream_monitor
    dec_item_t want;
    if (rst_n) begin
      if (dec_bus.valid && dec_bus.ready) begin
        if (dec_owed_q.size() == 0) begin
          $error("out_byte: nothing expected, got %h (out_last %b)",
                 dec_bus.out_byte, dec_bus.out_last);
          fail_cnt++;
        end else begin
          want = dec_owed_q.pop_front();
          decoded_cnt++;
          if (dec_bus.out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, dec_bus.out_byte);
            fail_cnt++;
          end
          if (dec_bus.out_last !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, dec_bus.out_last);
            fail_cnt++;
          end
        end
      end
      if (enc_bus.valid && enc_bus.ready) begin
        accept_cnt++;
        predict_decode(enc_bus.in_byte, enc_bus.in_last);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles with %0d bytes still owed",
               cycle_cnt, dec_owed_q.size());
      $display("** url_percent_decoder: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed strings, then random ones, then wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    int unsigned target;

    // Plain text with a plus sign.
    queue_text("a+b");
    // Complete escapes in both letter cases, ending on the second digit.
    queue_text("%41");
    queue_text("%fF");
    // A percent sign that is the final byte passes through as itself.
    queue_text("%");
    // The string ends one byte into an escape: percent, then a plus as a space.
    queue_text("%+");
    queue_text("%z");
    // A percent sign and a lower-case letter used as digits, with wrapping.
    queue_text("%%z");
    // Extremes of the byte: zero is ordinary data, not an end mark.
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);
    // Escape built from the extreme bytes.
    queue_byte(ChPercent, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    // A lone plus sign as a whole string.
    queue_text("+");

    // Random strings. The first one, and a few later ones, wait until the
    // decoder has delivered everything that it owes.
    target = enc_pending_q.size() + RandomItems;
    queue_random_string(1'b1);
    while (enc_pending_q.size() < target) begin
      queue_random_string($urandom_range(0, 149) == 0);
    end

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (enc_pending_q.size() != 0 || accept_cnt != issue_cnt) begin
      @(posedge clk);
    end
    while (dec_owed_q.size() != 0) begin
      @(posedge clk);
    end
    // A little more time so that any surplus output would still be caught.
    repeat (20) @(posedge clk);

    $display("Sent %0d strings in %0d encoded bytes; checked %0d decoded bytes,",
             string_cnt, accept_cnt, decoded_cnt);
    $display("among them %0d full escapes and %0d escapes cut short after one byte.",
             escape_cnt, split_cnt);
    if (fail_cnt == 0) begin
      $display("** url_percent_decoder: PASSED **");
    end else begin
      $display("** url_percent_decoder: FAILED **");
    end
    $finish;
  end

endmodule
